### rtl/mpts_pkg.sv
`timescale 1ns / 1ps

package mpts_pkg;

  // Field widths of the request and token channels.
  localparam int OP_W      = 2;
  localparam int IDX_W     = 10;
  localparam int SIZE_W    = 11;
  localparam int SEQ_W     = 32;
  localparam int ROUND_W   = 32;
  localparam int FLOW_W    = 32;
  localparam int PRIO_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Received map word geometry.
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  localparam int DEFAULT_MAX_PACKETS = 1024;

  // Marker for "no token issued yet".
  localparam logic [SIZE_W-1:0] LAST_NONE = '1;

  // Reset value of the flow size register.
  localparam logic [SIZE_W-1:0] FLOW_SIZE_RESET = SIZE_W'(1);

  // Request operations.
  typedef enum logic [OP_W-1:0] {
    OP_MARK  = 2'd0,
    OP_NEXT  = 2'd1,
    OP_GIVEN = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOW_SIZE  = 2'd0,
    CFG_THRESHOLD  = 2'd1,
    CFG_FLOW_IDENT = 2'd2,
    CFG_PRIORITY   = 2'd3
  } cfg_idx_t;

endpackage

### rtl/missing_packet_token_selector.sv
`timescale 1ns / 1ps
// Sequence: a mark request reads its map word in ST_MARK_RD and sets the bit in ST_MARK_WR;
// a given-index, unused or out-of-range mark request goes straight to ST_EMIT. A next-token
// request runs the ST_MOD remainder division first when the previous token index wraps, then
// ST_SCAN_INIT, and scans the 32-bit map words one by one in ST_SCAN, resuming at the restart
// index. Requests are taken one at a time, limited by the word-by-word scan of the map memory.
// Reset clears the status and config registers, then clears the map one word per cycle.
module missing_packet_token_selector #(
  parameter int MAX_PACKETS = mpts_pkg::DEFAULT_MAX_PACKETS
) (
  input  logic                             clk,
  input  logic                             rst,
  // Request channel.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mpts_pkg::OP_W-1:0]        operation,
  input  logic [mpts_pkg::IDX_W-1:0]       packet_index,
  input  logic [mpts_pkg::ROUND_W-1:0]     round_number,
  input  logic [mpts_pkg::IDX_W-1:0]       restart_index,
  // Token channel.
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             token_valid,
  output logic [mpts_pkg::IDX_W-1:0]       token_data_index,
  output logic [mpts_pkg::SEQ_W-1:0]       token_sequence,
  output logic [mpts_pkg::SIZE_W-1:0]      remaining_count,
  output logic [mpts_pkg::ROUND_W-1:0]     token_round,
  output logic [mpts_pkg::FLOW_W-1:0]      token_flow,
  output logic [mpts_pkg::PRIO_W-1:0]      token_priority,
  output logic                             nothing_missing,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mpts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpts_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import mpts_pkg::*;

  // Map storage covers only indexes that a mark can reach.
  localparam int MAP_ENTRIES = (MAX_PACKETS < (1 << IDX_W)) ? MAX_PACKETS : (1 << IDX_W);
  localparam int DEPTH       = (MAP_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EFF_CAP     = (MAX_PACKETS < (1 << SIZE_W) - 1) ? MAX_PACKETS
                                                                  : (1 << SIZE_W) - 1;
  // Scan positions and word numbers carry one spare bit for exclusive bounds.
  localparam int POS_W  = SIZE_W + 1;
  localparam int WIDX_W = POS_W - BIT_W;
  localparam int CNT_W  = $clog2(SIZE_W + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_MOD,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_TOKEN,
    RES_MISSING
  } res_kind_t;

  state_t               state;
  logic [ADDR_W-1:0]    clr_addr;

  // Configuration registers.
  logic [SIZE_W-1:0]    flow_size_pkts;
  logic [SIZE_W-1:0]    small_flow_threshold;
  logic [FLOW_W-1:0]    flow_ident;
  logic [PRIO_W-1:0]    flow_priority;

  // Flow status.
  logic [SIZE_W-1:0]    received_total;
  logic [SEQ_W-1:0]     token_counter;
  logic [SIZE_W-1:0]    last_token_index;

  // Request being worked on.
  logic [IDX_W-1:0]     req_pidx;
  logic [ROUND_W-1:0]   req_round;
  logic [SIZE_W-1:0]    restart_pos;
  logic [SIZE_W-1:0]    start_pos;

  // Remainder divider.
  logic [POS_W-1:0]     mod_rem;
  logic [SIZE_W-1:0]    mod_div;
  logic [CNT_W-1:0]     mod_cnt;

  // Scan window and read pipeline.
  logic [POS_W-1:0]     scan_lo;
  logic [POS_W-1:0]     scan_hi;
  logic                 scan_phase;
  logic [WIDX_W-1:0]    issue_word;
  logic                 chk_pend;
  logic [WIDX_W-1:0]    chk_word;
  logic                 chk_oob;

  // Pending result.
  res_kind_t            res_kind;
  logic [IDX_W-1:0]     res_idx;

  // Map memory.
  logic [WORD_W-1:0]    map_mem [DEPTH];
  logic [WORD_W-1:0]    rd_data;
  logic [ADDR_W-1:0]    mem_ra;
  logic [ADDR_W-1:0]    mem_wa;
  logic [WORD_W-1:0]    mem_wd;
  logic                 mem_we;

  // Combinational helpers.
  logic [SIZE_W-1:0]    eff;
  logic [SIZE_W-1:0]    last_p1;
  logic [SIZE_W-1:0]    restart_sel;
  logic [POS_W-1:0]     hi_m1;
  logic [WIDX_W-1:0]    first_word;
  logic [WIDX_W-1:0]    last_word;
  logic                 issue_oob;
  logic [WORD_W-1:0]    chk_data;
  logic [WORD_W-1:0]    lo_mask;
  logic [WORD_W-1:0]    hi_mask;
  logic [WORD_W-1:0]    cand;
  logic                 hit;
  logic [BIT_W-1:0]     hit_bit;
  logic [POS_W-1:0]     hit_pos;
  logic [POS_W-1:0]     p2_sum;
  logic [POS_W-1:0]     p2_hi;
  logic [POS_W-1:0]     mod_step;
  logic [POS_W-1:0]     mod_rem_next;
  logic                 mark_bit;
  logic [SIZE_W-1:0]    remaining;
  logic                 slot_free;
  logic                 res_is_token;

  // Register writes wait until no request is in flight and go ahead of a new request.
  assign in_ready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE) && !out_valid;
  assign slot_free = !out_valid || out_ready;
  assign res_is_token = (res_kind == RES_TOKEN);

  // Flow size as seen by marks and scans.
  assign eff = (flow_size_pkts < SIZE_W'(EFF_CAP)) ? flow_size_pkts : SIZE_W'(EFF_CAP);
  assign last_p1 = last_token_index + SIZE_W'(1);
  assign restart_sel = ({1'b0, restart_index} < eff) ? {1'b0, restart_index} : '0;
  assign remaining = (flow_size_pkts > received_total) ? (flow_size_pkts - received_total)
                                                        : '0;

  // Word bounds of the current scan window.
  assign hi_m1      = scan_hi - POS_W'(1);
  assign first_word = scan_lo[POS_W-1:BIT_W];
  assign last_word  = hi_m1[POS_W-1:BIT_W];
  assign issue_oob  = (issue_word >= WIDX_W'(DEPTH));

  // Unreceived bits of the checked word that fall inside the window.
  assign chk_data = chk_oob ? '0 : rd_data;
  assign lo_mask  = (chk_word == first_word) ? ({WORD_W{1'b1}} << scan_lo[BIT_W-1:0])
                                             : {WORD_W{1'b1}};
  assign hi_mask  = (chk_word == last_word)
                  ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_m1[BIT_W-1:0]))
                  : {WORD_W{1'b1}};
  assign cand     = ~chk_data & lo_mask & hi_mask;

  // Lowest unreceived bit of the checked word.
  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit     = 1'b1;
        hit_bit = BIT_W'(b);
      end
    end
  end
  assign hit_pos = {chk_word, hit_bit};

  // Second scan window runs from the restart point for as many positions as were skipped.
  assign p2_sum = {1'b0, restart_pos} + {1'b0, start_pos};
  assign p2_hi  = (p2_sum < {1'b0, eff}) ? p2_sum : {1'b0, eff};

  // One restoring division step.
  assign mod_step     = {mod_rem[SIZE_W-1:0], mod_div[SIZE_W-1]};
  assign mod_rem_next = (mod_step >= {1'b0, eff}) ? (mod_step - {1'b0, eff}) : mod_step;

  assign mark_bit = rd_data[req_pidx[BIT_W-1:0]];

  // Memory port control.
  always_comb begin
    mem_ra = issue_word[ADDR_W-1:0];
    mem_we = 1'b0;
    mem_wa = ADDR_W'(req_pidx >> BIT_W);
    mem_wd = rd_data | (WORD_W'(1) << req_pidx[BIT_W-1:0]);
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        mem_wd = '0;
      end
      ST_MARK_RD: begin
        mem_ra = ADDR_W'(req_pidx >> BIT_W);
      end
      ST_MARK_WR: begin
        mem_we = !mark_bit;
      end
      default: begin
      end
    endcase
  end

  // Received map memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    rd_data <= map_mem[mem_ra];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      flow_size_pkts       <= FLOW_SIZE_RESET;
      small_flow_threshold <= '0;
      flow_ident           <= '0;
      flow_priority        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FLOW_SIZE:  flow_size_pkts       <= cfg_data[SIZE_W-1:0];
        CFG_THRESHOLD:  small_flow_threshold <= cfg_data[SIZE_W-1:0];
        CFG_FLOW_IDENT: flow_ident           <= cfg_data[FLOW_W-1:0];
        CFG_PRIORITY:   flow_priority        <= cfg_data[PRIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request sequencer, status registers and token register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      clr_addr         <= '0;
      received_total   <= '0;
      token_counter    <= '0;
      last_token_index <= LAST_NONE;
      chk_pend         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      // A taken token frees the register unless a new one is loaded.
      if (out_ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_valid && in_ready) begin
            req_pidx    <= packet_index;
            req_round   <= round_number;
            restart_pos <= restart_sel;
            res_idx     <= packet_index;
            unique case (operation)
              OP_MARK: begin
                res_kind <= RES_NONE;
                if ({1'b0, packet_index} < eff) begin
                  state <= ST_MARK_RD;
                end else begin
                  state <= ST_EMIT;
                end
              end
              OP_NEXT: begin
                if (eff == '0) begin
                  res_kind <= RES_MISSING;
                  state    <= ST_EMIT;
                end else if (last_token_index == LAST_NONE) begin
                  res_kind  <= RES_NONE;
                  start_pos <= '0;
                  state     <= ST_SCAN_INIT;
                end else if (last_p1 < eff) begin
                  res_kind  <= RES_NONE;
                  start_pos <= last_p1;
                  state     <= ST_SCAN_INIT;
                end else begin
                  res_kind <= RES_NONE;
                  mod_rem  <= '0;
                  mod_div  <= last_p1;
                  mod_cnt  <= '0;
                  state    <= ST_MOD;
                end
              end
              OP_GIVEN: begin
                res_kind <= RES_TOKEN;
                state    <= ST_EMIT;
              end
              default: begin
                res_kind <= RES_NONE;
                state    <= ST_EMIT;
              end
            endcase
          end
        end

        ST_MARK_RD: begin
          state <= ST_MARK_WR;
        end

        // Set the bit; a packet seen before is not counted again.
        ST_MARK_WR: begin
          if (!mark_bit && (received_total != {SIZE_W{1'b1}})) begin
            received_total <= received_total + SIZE_W'(1);
          end
          state <= ST_EMIT;
        end

        // Scan start is (last + 1) mod size when it wraps the flow.
        ST_MOD: begin
          mod_rem <= mod_rem_next;
          mod_div <= mod_div << 1;
          mod_cnt <= mod_cnt + CNT_W'(1);
          if (mod_cnt == CNT_W'(SIZE_W - 1)) begin
            start_pos <= mod_rem_next[SIZE_W-1:0];
            state     <= ST_SCAN_INIT;
          end
        end

        ST_SCAN_INIT: begin
          scan_lo    <= {1'b0, start_pos};
          scan_hi    <= {1'b0, eff};
          scan_phase <= 1'b0;
          issue_word <= WIDX_W'(start_pos >> BIT_W);
          chk_pend   <= 1'b0;
          state      <= ST_SCAN;
        end

        // One word read per cycle, checked the cycle after.
        ST_SCAN: begin
          if (chk_pend && hit) begin
            chk_pend <= 1'b0;
            res_kind <= RES_TOKEN;
            res_idx  <= hit_pos[IDX_W-1:0];
            state    <= ST_EMIT;
          end else if (issue_word <= last_word) begin
            chk_pend   <= 1'b1;
            chk_word   <= issue_word;
            chk_oob    <= issue_oob;
            issue_word <= issue_word + WIDX_W'(1);
          end else begin
            chk_pend <= 1'b0;
            if (!scan_phase && (start_pos != '0)) begin
              scan_lo    <= {1'b0, restart_pos};
              scan_hi    <= p2_hi;
              scan_phase <= 1'b1;
              issue_word <= WIDX_W'(restart_pos >> BIT_W);
            end else begin
              res_kind <= RES_MISSING;
              state    <= ST_EMIT;
            end
          end
        end

        // Load the token register once it is free.
        ST_EMIT: begin
          if (slot_free) begin
            out_valid        <= 1'b1;
            token_valid      <= res_is_token;
            token_data_index <= res_is_token ? res_idx : '0;
            token_sequence   <= res_is_token ? token_counter : '0;
            remaining_count  <= res_is_token ? remaining : '0;
            token_round      <= (res_is_token && (flow_size_pkts > small_flow_threshold))
                                ? req_round : '0;
            token_flow       <= res_is_token ? flow_ident : '0;
            token_priority   <= res_is_token ? flow_priority : '0;
            nothing_missing  <= (res_kind == RES_MISSING);
            if (res_is_token) begin
              token_counter    <= token_counter + SEQ_W'(1);
              last_token_index <= {1'b0, res_idx};
            end
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A scan must start inside the flow.
  a_start_in_flow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_INIT) |-> (start_pos < eff))
    else $error("scan start outside the flow");

  // The map is never written while a scan reads it.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !mem_we)
    else $error("map write during scan");

  // Each issued token advances the counter by exactly one.
  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EMIT) && slot_free && (res_kind == RES_TOKEN))
      |=> (token_counter == $past(token_counter) + SEQ_W'(1)))
    else $error("token counter did not advance");

  // Distinct marked packets can never outnumber the map.
  a_total_bounded: assert property (@(posedge clk) disable iff (rst)
    received_total <= SIZE_W'(MAP_ENTRIES))
    else $error("received count exceeds map size");

  // A token names the index it was issued for.
  a_last_tracks_token: assert property (@(posedge clk) disable iff (rst)
    (out_valid && token_valid && $rose(out_valid))
      |-> (last_token_index == {1'b0, token_data_index}))
    else $error("last token index out of step");

endmodule

### dv/token_checker.sv
`timescale 1ns / 1ps

module token_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [mpts_pkg::OP_W-1:0]       operation,
  input  logic [mpts_pkg::IDX_W-1:0]      packet_index,
  input  logic [mpts_pkg::ROUND_W-1:0]    round_number,
  input  logic [mpts_pkg::IDX_W-1:0]      restart_index,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            token_valid,
  input  logic [mpts_pkg::IDX_W-1:0]      token_data_index,
  input  logic [mpts_pkg::SEQ_W-1:0]      token_sequence,
  input  logic [mpts_pkg::SIZE_W-1:0]     remaining_count,
  input  logic [mpts_pkg::ROUND_W-1:0]    token_round,
  input  logic [mpts_pkg::FLOW_W-1:0]     token_flow,
  input  logic [mpts_pkg::PRIO_W-1:0]     token_priority,
  input  logic                            nothing_missing,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mpts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpts_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending_count
);
  import mpts_pkg::*;

  localparam int MAP_DEPTH    = DEFAULT_MAX_PACKETS;
  localparam int REPORT_LIMIT = 10;

  // One token as it appears on the output channel, in port order.
  typedef struct packed {
    logic               issued;
    logic [IDX_W-1:0]   pkt_index;
    logic [SEQ_W-1:0]   seq_no;
    logic [SIZE_W-1:0]  remaining;
    logic [ROUND_W-1:0] round_no;
    logic [FLOW_W-1:0]  flow;
    logic [PRIO_W-1:0]  prio;
    logic               none_missing;
  } token_t;

  // Mirror of the flow state and its registers.
  logic [MAP_DEPTH-1:0] received;
  logic [SIZE_W-1:0]    received_total;
  logic [SEQ_W-1:0]     token_counter;
  logic [SIZE_W-1:0]    last_index;
  logic [SIZE_W-1:0]    flow_size;
  logic [SIZE_W-1:0]    small_threshold;
  logic [FLOW_W-1:0]    flow_id;
  logic [PRIO_W-1:0]    flow_prio;

  token_t expected_tokens[$];
  int     mismatch_count = 0;

  function automatic void reset_flow();
    received        = '0;
    received_total  = '0;
    token_counter   = '0;
    last_index      = LAST_NONE;
    flow_size       = FLOW_SIZE_RESET;
    small_threshold = '0;
    flow_id         = '0;
    flow_prio       = '0;
    expected_tokens.delete();
  endfunction

  function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_FLOW_SIZE:  flow_size       = data[SIZE_W-1:0];
      CFG_THRESHOLD:  small_threshold = data[SIZE_W-1:0];
      CFG_FLOW_IDENT: flow_id         = data[FLOW_W-1:0];
      CFG_PRIORITY:   flow_prio       = data[PRIO_W-1:0];
      default: ;
    endcase
  endfunction

  // The map only covers MAX_PACKETS entries, so larger flows are clipped.
  function automatic int active_size();
    return (flow_size > MAP_DEPTH) ? MAP_DEPTH : int'(flow_size);
  endfunction

  function automatic token_t issue_token(logic [IDX_W-1:0] idx, logic [ROUND_W-1:0] rnd);
    token_t tok;
    tok           = '0;
    tok.issued    = 1'b1;
    tok.pkt_index = idx;
    tok.seq_no    = token_counter;
    tok.remaining = (flow_size > received_total) ? flow_size - received_total : '0;
    tok.round_no  = (flow_size > small_threshold) ? rnd : '0;
    tok.flow      = flow_id;
    tok.prio      = flow_prio;
    last_index    = {1'b0, idx};
    token_counter = token_counter + 1'b1;
    return tok;
  endfunction

  // Applies one request to the mirrored state and returns the token it yields.
  function automatic token_t predict_token(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                           logic [ROUND_W-1:0] rnd,
                                           logic [IDX_W-1:0] restart);
    token_t tok;
    int     span;
    int     pos;
    int     resume;
    int     looked;
    bit     found;
    tok   = '0;
    span  = active_size();
    found = 1'b0;
    pos   = 0;
    case (op)
      OP_MARK: begin
        if (idx < span && !received[idx]) begin
          received[idx] = 1'b1;
          if (received_total != '1) received_total = received_total + 1'b1;
        end
      end
      OP_NEXT: begin
        if (span != 0) begin
          resume = (restart >= span) ? 0 : int'(restart);
          pos    = (last_index == LAST_NONE) ? 0 : (int'(last_index) + 1) % span;
          looked = 0;
          // Walk at most one flow length, jumping to the restart point at the end.
          while (!found && looked < span) begin
            if (!received[pos]) begin
              found = 1'b1;
            end else begin
              pos++;
              if (pos >= span) pos = resume;
              looked++;
            end
          end
        end
        if (found) tok = issue_token(IDX_W'(pos), rnd);
        else tok.none_missing = 1'b1;
      end
      OP_GIVEN: tok = issue_token(idx, rnd);
      default: ;
    endcase
    return tok;
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, fname, want, got);
    end
  endfunction

  // Results are compared before new requests are queued, so a token that
  // shows up with nothing outstanding is caught.
  always @(posedge clk) begin : monitor
    token_t want;
    token_t got;
    if (rst) begin
      reset_flow();
    end else begin
      if (out_valid && out_ready) begin
        got = {token_valid, token_data_index, token_sequence, remaining_count,
               token_round, token_flow, token_priority, nothing_missing};
        if (expected_tokens.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: token with no request outstanding", $time);
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_valid", want.issued, got.issued);
          check_field("token_data_index", want.pkt_index, got.pkt_index);
          check_field("token_sequence", want.seq_no, got.seq_no);
          check_field("remaining_count", want.remaining, got.remaining);
          check_field("token_round", want.round_no, got.round_no);
          check_field("token_flow", want.flow, got.flow);
          check_field("token_priority", want.prio, got.prio);
          check_field("nothing_missing", want.none_missing, got.none_missing);
        end
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_valid && in_ready)
        expected_tokens.push_back(predict_token(operation, packet_index, round_number,
                                                restart_index));
    end
    mismatches    <= mismatch_count;
    pending_count <= expected_tokens.size();
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mpts_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RESET_CYCLES    = 11;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int PRESSURE_ITEMS  = 130;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT  = 3000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       operation = '0;
  logic [IDX_W-1:0]      packet_index = '0;
  logic [ROUND_W-1:0]    round_number = '0;
  logic [IDX_W-1:0]      restart_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  token_valid;
  logic [IDX_W-1:0]      token_data_index;
  logic [SEQ_W-1:0]      token_sequence;
  logic [SIZE_W-1:0]     remaining_count;
  logic [ROUND_W-1:0]    token_round;
  logic [FLOW_W-1:0]     token_flow;
  logic [PRIO_W-1:0]     token_priority;
  logic                  nothing_missing;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int pending_count;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holds_asked    = 0;
  int holds_granted  = 0;
  int flow_size_now  = 1;
  int quiet_cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  missing_packet_token_selector DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .packet_index     (packet_index),
    .round_number     (round_number),
    .restart_index    (restart_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .token_valid      (token_valid),
    .token_data_index (token_data_index),
    .token_sequence   (token_sequence),
    .remaining_count  (remaining_count),
    .token_round      (token_round),
    .token_flow       (token_flow),
    .token_priority   (token_priority),
    .nothing_missing  (nothing_missing),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  token_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .packet_index     (packet_index),
    .round_number     (round_number),
    .restart_index    (restart_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .token_valid      (token_valid),
    .token_data_index (token_data_index),
    .token_sequence   (token_sequence),
    .remaining_count  (remaining_count),
    .token_round      (token_round),
    .token_flow       (token_flow),
    .token_priority   (token_priority),
    .nothing_missing  (nothing_missing),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .pending_count    (pending_count)
  );

  // Abort if no channel has moved anything for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Token receiver: random stalls, plus a long hold-off when one is asked for.
  initial begin : token_sink
    forever begin
      @(negedge clk);
      if (holds_granted < holds_asked) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_granted++;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                              logic [ROUND_W-1:0] rnd, logic [IDX_W-1:0] restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    operation     = op;
    packet_index  = idx;
    round_number  = rnd;
    restart_index = restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == CFG_FLOW_SIZE) flow_size_now = int'(data[SIZE_W-1:0]);
  endtask

  task automatic configure_flow(int pkts, int threshold, logic [FLOW_W-1:0] ident,
                                logic [PRIO_W-1:0] prio);
    write_register(CFG_FLOW_SIZE, CFG_DATA_W'(pkts));
    write_register(CFG_THRESHOLD, CFG_DATA_W'(threshold));
    write_register(CFG_FLOW_IDENT, ident);
    write_register(CFG_PRIORITY, CFG_DATA_W'(prio));
  endtask

  // Stop offering requests and wait until every token has come back.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
      default: begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
  endtask

  // Flow sizes grow from phase to phase, so later phases still find fresh
  // unreceived packets in the map, which is never cleared.
  function automatic int planned_size(int phase);
    case (phase)
      0: return 1;
      1: return 12 + $urandom_range(3);
      2: return 33 + $urandom_range(8);
      3: return 80 + $urandom_range(20);
      4: return 190 + $urandom_range(40);
      5: return 420 + $urandom_range(80);
      6: return 760 + $urandom_range(100);
      default: return DEFAULT_MAX_PACKETS;
    endcase
  endfunction

  // Mostly in-flow indexes for marks and restarts, with some past the end.
  task automatic random_request();
    int               span;
    int               pick;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] restart;
    span = (flow_size_now > DEFAULT_MAX_PACKETS) ? DEFAULT_MAX_PACKETS : flow_size_now;
    if (span > 0 && $urandom_range(9) != 0) idx = IDX_W'($urandom_range(span - 1));
    else idx = IDX_W'($urandom);
    if (span > 0 && $urandom_range(7) != 0) restart = IDX_W'($urandom_range(span - 1));
    else restart = IDX_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 45)      send_request(OP_MARK, idx, $urandom, restart);
    else if (pick < 85) send_request(OP_NEXT, idx, $urandom, restart);
    else if (pick < 95) send_request(OP_GIVEN, idx, $urandom, restart);
    else                send_request(OP_UNUSED, idx, $urandom, restart);
  endtask

  initial begin : stimulus
    int phase;
    int n;
    int span;
    int threshold;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty flow: the scan finds nothing, marks are ignored, a given index
    // still yields a token, and the unused operation does nothing.
    configure_flow(0, 0, 32'hFFFF_FFFF, 8'hFF);
    send_request(OP_NEXT, '0, 32'hFFFF_FFFF, '0);
    send_request(OP_MARK, '0, '0, '0);
    send_request(OP_GIVEN, 10'd1023, 32'hFFFF_FFFF, 10'd1023);
    send_request(OP_UNUSED, 10'd1023, 32'hFFFF_FFFF, 10'd1023);
    wait_idle();

    // Small flow below the threshold: round is zeroed. The last token index
    // lies past the flow, marks repeat or fall outside it, and the restart
    // index is out of range, until the whole flow is received.
    configure_flow(4, 8, '0, '0);
    send_request(OP_NEXT, '0, 32'h1234_5678, '0);
    send_request(OP_MARK, 10'd0, '0, '0);
    send_request(OP_MARK, 10'd0, '0, '0);
    send_request(OP_MARK, 10'd3, '0, '0);
    send_request(OP_MARK, 10'd5, '0, '0);
    send_request(OP_NEXT, '0, 32'h8765_4321, 10'd9);
    send_request(OP_MARK, 10'd1, '0, '0);
    send_request(OP_MARK, 10'd2, '0, '0);
    send_request(OP_NEXT, '0, 32'hFFFF_FFFF, 10'd1);
    send_request(OP_GIVEN, 10'd2, 32'hFFFF_FFFF, '0);
    wait_idle();

    // Flow larger than the map: clipped to MAX_PACKETS, round passed through,
    // and a scan that runs off the end and resumes at the restart index.
    configure_flow(2047, 1024, 32'h5A5A_A5A5, 8'h80);
    send_request(OP_NEXT, '0, 32'hDEAD_BEEF, 10'd1023);
    send_request(OP_GIVEN, 10'd1022, 32'h0000_0001, '0);
    send_request(OP_MARK, 10'd1023, '0, '0);
    send_request(OP_NEXT, '0, 32'h8000_0000, 10'd2);
    send_request(OP_NEXT, '0, 32'h7FFF_FFFF, 10'd2);
    wait_idle();

    // Random phases, each with its own flow settings and idling pattern.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      span = planned_size(phase);
      case ($urandom_range(3))
        0: threshold = 0;
        1: threshold = DEFAULT_MAX_PACKETS;
        2: threshold = span;
        default: threshold = $urandom_range(DEFAULT_MAX_PACKETS);
      endcase
      configure_flow(span, threshold, $urandom, PRIO_W'($urandom));
      set_idling(phase % 4);
      for (n = 0; n < ITEMS_PER_PHASE; n++) random_request();
      wait_idle();
    end

    // Backpressure: the receiver holds off while requests keep coming, and
    // halfway through the sender waits for every token to drain.
    configure_flow(DEFAULT_MAX_PACKETS, DEFAULT_MAX_PACKETS, '0, '0);
    set_idling(0);
    holds_asked++;
    for (n = 0; n < PRESSURE_ITEMS; n++) begin
      if (n == PRESSURE_ITEMS / 2) wait_idle();
      random_request();
    end
    wait_idle();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
